// ----- rtl/eat_pkg.sv -----
// Package for the expiring avoid table: operation codes and the packed
// command and response transaction types.
// No dependencies; used by rtl/expiring_avoid_table.sv.
`default_nettype none

package eat_pkg;

    // Operation codes of the command transaction. The fourth code is unused
    // and leaves the table untouched.
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_PRUNE = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] entry_id;
        logic [31:0] time_value;
    } cmd_t;

    typedef struct packed {
        logic       answer;
        logic [4:0] entries_in_use;
    } rsp_t;

endpackage : eat_pkg

`default_nettype wire

// ----- rtl/expiring_avoid_table.sv -----
// Expiring avoid table: an ordered table of id and expiry pairs with add,
// query and prune operations, scanned one entry per cycle.
// Depends on rtl/eat_pkg.sv for the op codes and transaction types.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+----------------------------
//  cmd     | into      | cmd_valid / cmd_stall | eat_pkg::cmd_t (op, id, time)
//  rsp     | out of    | rsp_valid / rsp_stall | eat_pkg::rsp_t (answer, count)
//
// In a command transaction the scan reads one table entry per cycle through
// the single registered read port of the entry memory, so the fill count
// sets how long the transaction runs (a full table holds 16 entries by
// default). The command side stalls from acceptance until the result has
// been placed in the response register. A finished response waits there
// while the next command is accepted and worked on. Reset clears the fill
// count and all control state; the memory contents are not cleared.
`default_nettype none

module expiring_avoid_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire eat_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output eat_pkg::rsp_t      rsp
);

    // Count must hold CAPACITY itself; the index only needs the depth.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Entry memory: one write port, one registered read port.
    logic [15:0]      ids_mem [CAPACITY];
    logic [31:0]      exp_mem [CAPACITY];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [15:0]      mem_wid;
    logic [31:0]      mem_wexp;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [15:0]      rd_id_reg;
    logic [31:0]      rd_exp_reg;

    state_t           state_reg,    state_next;
    logic [1:0]       op_reg,       op_next;
    logic [15:0]      id_reg,       id_next;
    logic [31:0]      time_reg,     time_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [CNT_W-1:0] issue_reg,    issue_next;
    logic             pend_reg,     pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0] wr_reg,       wr_next;
    logic [31:0]      least_reg,    least_next;
    logic [IDX_W-1:0] victim_reg,   victim_next;
    logic             answer_reg,   answer_next;
    logic             rsp_valid_reg, rsp_valid_next;
    eat_pkg::rsp_t    rsp_reg,      rsp_next;

    logic             issuing;
    logic             hit;
    logic [CNT_W+4:0] count_wide;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Entries below the fill count are still to be read in this scan.
    assign issuing    = (issue_reg < count_reg);
    assign hit        = (rd_id_reg == id_reg);
    assign count_wide = {5'd0, count_reg};
    assign mem_re     = (state_reg == ST_SCAN) && issuing;
    assign mem_raddr  = issue_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ids_mem[mem_waddr] <= mem_wid;
            exp_mem[mem_waddr] <= mem_wexp;
        end
        if (mem_re)
        begin
            rd_id_reg  <= ids_mem[mem_raddr];
            rd_exp_reg <= exp_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        time_next      = time_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        wr_next        = wr_reg;
        least_next     = least_reg;
        victim_next    = victim_reg;
        answer_next    = answer_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_idx_reg;
        mem_wid        = id_reg;
        mem_wexp       = time_reg;

        // The waiting response is taken by the consumer.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next     = cmd.op;
                    id_next     = cmd.entry_id;
                    time_next   = cmd.time_value;
                    issue_next  = '0;
                    wr_next     = '0;
                    answer_next = 1'b0;
                    if (cmd.op == eat_pkg::OP_ADD || cmd.op == eat_pkg::OP_QUERY ||
                        cmd.op == eat_pkg::OP_PRUNE)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // Unused code: nothing changes, answer is zero.
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (pend_reg && op_reg == eat_pkg::OP_ADD && hit)
                begin
                    // Refresh the first entry holding this id.
                    mem_we      = 1'b1;
                    mem_waddr   = pend_idx_reg;
                    answer_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (pend_reg && op_reg == eat_pkg::OP_QUERY && hit)
                begin
                    // The first matching entry decides; later ones are ignored.
                    answer_next = (rd_exp_reg > time_reg);
                    state_next  = ST_DONE;
                end
                else if (!pend_reg && !issuing)
                begin
                    // Scan exhausted without an early stop.
                    if (op_reg == eat_pkg::OP_ADD)
                    begin
                        mem_we      = 1'b1;
                        answer_next = 1'b1;
                        if (count_reg < CNT_W'(CAPACITY))
                        begin
                            mem_waddr  = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            mem_waddr = victim_reg;
                        end
                    end
                    else if (op_reg == eat_pkg::OP_PRUNE)
                    begin
                        count_next = wr_reg;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    if (pend_reg && op_reg == eat_pkg::OP_ADD)
                    begin
                        // Track the earliest expiry; ties keep the lower index.
                        if (pend_idx_reg == '0 || rd_exp_reg < least_reg)
                        begin
                            least_next  = rd_exp_reg;
                            victim_next = pend_idx_reg;
                        end
                    end
                    if (pend_reg && op_reg == eat_pkg::OP_PRUNE &&
                        rd_exp_reg > time_reg)
                    begin
                        // Compact surviving entries towards the front.
                        mem_we    = 1'b1;
                        mem_waddr = wr_reg[IDX_W-1:0];
                        mem_wid   = rd_id_reg;
                        mem_wexp  = rd_exp_reg;
                        wr_next   = wr_reg + 1'b1;
                    end
                    pend_next     = issuing;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    if (issuing)
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.answer         = answer_reg;
                    rsp_next.entries_in_use = count_wide[4:0];
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            id_reg        <= '0;
            time_reg      <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            wr_reg        <= '0;
            least_reg     <= '0;
            victim_reg    <= '0;
            answer_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            id_reg        <= id_next;
            time_reg      <= time_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            wr_reg        <= wr_next;
            least_reg     <= least_next;
            victim_reg    <= victim_next;
            answer_reg    <= answer_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule : expiring_avoid_table

`default_nettype wire
